// ----- rtl/dmpi_pkg.sv -----
// ----------------------------------------------------------------------------
// dmpi_pkg
// Shared types, widths and constants of the dual motor speed regulator.
// ----------------------------------------------------------------------------
package dmpi_pkg;

  // default number of motors
  localparam int MOTORS_DEF = 2;

  // shared multiplier operand and product widths
  localparam int MUL_W  = 25;
  localparam int PROD_W = 2 * MUL_W;

  // datapath widths
  localparam int SPEED_W = 20;
  localparam int ERR_W   = 21;
  localparam int DIFF_W  = 22;
  localparam int INTEG_W = 37;
  localparam int LO_W    = 18;
  localparam int TLO_W   = 42;
  localparam int IFULL_W = 61;
  localparam int SUM_W   = 48;
  localparam int DRVF_W  = SUM_W - 20;
  localparam int DUTY_W  = 15;
  localparam int CMP_W   = 16;
  localparam int CFG_W   = 36;

  localparam logic [SPEED_W-1:0] SPEED_MAX  = 20'hFFFFF;
  localparam logic [DUTY_W-1:0]  FULL_DRIVE = 15'd25600;
  // ceil(2^30 / 100), exact quotient for dividends below 2^23
  localparam logic [23:0]        RECIP_100  = 24'd10737419;

  typedef enum logic [1:0] {
    FUNC_TICK,
    FUNC_TARGET,
    FUNC_DIR,
    FUNC_ESTOP
  } func_t;

  typedef enum logic [2:0] {
    REG_RPM_PER_PULSE,
    REG_PERIOD_SECONDS,
    REG_PROP_GAIN,
    REG_INTEG_GAIN,
    REG_DERIV_GAIN,
    REG_INTEGRAL_LIMIT,
    REG_DRIVE_LIMIT,
    REG_PWM_PERIOD
  } reg_idx_t;

  typedef struct packed {
    logic [15:0] rpm_per_pulse;
    logic [15:0] period_seconds;
    logic [23:0] prop_gain;
    logic [23:0] integ_gain;
    logic [23:0] deriv_gain_per_period;
    logic [35:0] integral_limit;
    logic [14:0] drive_limit;
    logic [15:0] pwm_period_ticks;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    rpm_per_pulse:         16'd6000,
    period_seconds:        16'd655,
    prop_gain:             24'd33554,
    integ_gain:            24'd83886,
    deriv_gain_per_period: 24'd0,
    integral_limit:        36'd20971520000,
    drive_limit:           15'd7680,
    pwm_period_ticks:      16'd50
  };

  typedef enum logic [3:0] {
    S_IDLE,
    S_DECODE,
    S_SPEED,
    S_ERR,
    S_INTEG,
    S_PROP,
    S_ILO,
    S_IHI,
    S_DER,
    S_SUM,
    S_DRIVE,
    S_DUTY,
    S_PWM,
    S_SCALE,
    S_CMP,
    S_DONE
  } state_t;

endpackage

// ----- rtl/dmpi_if.sv -----
// ----------------------------------------------------------------------------
// dmpi_if
// Command and response channels of the speed regulator, valid/ready.
// ----------------------------------------------------------------------------

// command word channel
interface dmpi_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        motor;
  logic [13:0] pulses;
  logic [19:0] target_speed;
  logic        new_direction;

  modport source (output valid, func, motor, pulses, target_speed, new_direction,
                  input ready);
  modport sink   (input valid, func, motor, pulses, target_speed, new_direction,
                  output ready);
endinterface

// response word channel
interface dmpi_rsp_if;
  logic        valid;
  logic        ready;
  logic        motor_out;
  logic [15:0] compare_value;
  logic        brake_level;
  logic        direction_level;
  logic        running;
  logic [19:0] measured_speed;
  logic        ignored;

  modport source (output valid, motor_out, compare_value, brake_level, direction_level,
                  running, measured_speed, ignored, input ready);
  modport sink   (input valid, motor_out, compare_value, brake_level, direction_level,
                  running, measured_speed, ignored, output ready);
endinterface

// ----- rtl/dual_motor_speed_pi_controller.sv -----
// ----------------------------------------------------------------------------
// dual_motor_speed_pi_controller
// PI(D) speed regulator for up to MOTORS motors in fixed point.
// ----------------------------------------------------------------------------
// Usage: each command word on cmd addresses one motor: control tick, set
// target, set direction or emergency stop. Every command gives exactly one
// response word on rsp that reports the addressed motor after the step.
// Configuration registers are written through cfg_we/cfg_index/cfg_data; the
// user must do so only while the block is idle, the block does not enforce it.
// Sequencing: the work of a control tick on a running motor, from accept
// until its response is loaded and the next command can be taken, is set
// by eight passes through the one shared 25x25 multiplier plus the add,
// clamp and scale steps between them. Other commands and ticks on a stopped
// motor go from S_DECODE straight to S_DONE.
// One command is in work at a time; cmd.ready is high only while the
// sequencer is idle.
// The response register frees the input side: the next command is taken
// while a response still waits, and the sequencer holds its finished word
// until the receiver takes the previous one.
// Reset: all motors stopped, every per-motor store zero, registers at their
// defaults, no response pending.
// ----------------------------------------------------------------------------
module dual_motor_speed_pi_controller #(
  parameter int MOTORS = dmpi_pkg::MOTORS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  dmpi_cmd_if.sink                   cmd,
  dmpi_rsp_if.source                 rsp,
  input  logic                       cfg_we,
  input  logic [2:0]                 cfg_index,
  input  logic [dmpi_pkg::CFG_W-1:0] cfg_data
);
  import dmpi_pkg::*;

  localparam int MIDX_W = (MOTORS > 1) ? $clog2(MOTORS) : 1;

  cfg_t cfg;

  state_t state, state_next;

  // latched command word
  func_t              func_q;
  logic               motor_q;
  logic [13:0]        pulses_q;
  logic [19:0]        tgt_q;
  logic               dir_q;

  // per-motor state
  logic [SPEED_W-1:0]        target_store     [MOTORS];
  logic [SPEED_W-1:0]        speed_store      [MOTORS];
  logic                      running_flags    [MOTORS];
  logic signed [INTEG_W-1:0] integral_store   [MOTORS];
  logic signed [ERR_W-1:0]   last_error_store [MOTORS];
  logic [CMP_W-1:0]          compare_store    [MOTORS];
  logic                      brake_store      [MOTORS];
  logic                      direction_store  [MOTORS];

  // datapath registers
  logic signed [ERR_W-1:0]   err;
  logic signed [DIFF_W-1:0]  diff;
  logic signed [INTEG_W-1:0] integ;
  logic [TLO_W-1:0]          t_lo;
  logic signed [IFULL_W-1:0] ifull;
  logic signed [SUM_W-1:0]   sum;
  logic [DUTY_W-1:0]         drive;
  logic [DUTY_W-1:0]         duty;
  logic                      ign;

  // shared multiplier
  logic                      mul_en;
  logic signed [MUL_W-1:0]   mul_a;
  logic signed [MUL_W-1:0]   mul_b;
  logic signed [PROD_W-1:0]  prod;

  logic [MIDX_W-1:0] mi;
  logic              in_range;
  logic              busy;
  logic              tick_go;
  logic              out_free;
  logic              accept;

  // combinational datapath values
  logic [SPEED_W-1:0]        spd_sat;
  logic signed [INTEG_W:0]   isum;
  logic signed [INTEG_W:0]   lim_pos;
  logic signed [INTEG_W:0]   lim_neg;
  logic signed [DRVF_W-1:0]  drive_full;
  logic [16:0]               quot;

  dmpi_cfg u_cfg (
    .clk   (clk),
    .rst   (rst),
    .we    (cfg_we),
    .index (cfg_index),
    .data  (cfg_data),
    .cfg   (cfg)
  );

  dmpi_mul u_mul (
    .clk  (clk),
    .en   (mul_en),
    .a    (mul_a),
    .b    (mul_b),
    .prod (prod)
  );

  assign mi       = MIDX_W'(motor_q);
  assign in_range = (MOTORS > 1) || (motor_q == 1'b0);
  assign busy     = (target_store[mi] != '0) || running_flags[mi];
  assign tick_go  = in_range && (func_q == FUNC_TICK) && running_flags[mi]
                    && (target_store[mi] > 20'd1);
  assign out_free = !rsp.valid || rsp.ready;
  assign accept   = cmd.valid && cmd.ready;
  assign cmd.ready = (state == S_IDLE);

  // speed saturation, integral clamp, drive and compare scaling
  assign spd_sat    = (prod[29:20] != '0) ? SPEED_MAX : prod[19:0];
  assign isum       = (INTEG_W+1)'(integral_store[mi]) + $signed(prod[INTEG_W:0]);
  assign lim_pos    = $signed({2'b00, cfg.integral_limit});
  assign lim_neg    = -lim_pos;
  assign drive_full = DRVF_W'(sum >>> 20);
  assign quot       = prod[46:30];

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE:   if (accept) state_next = S_DECODE;
      S_DECODE: state_next = tick_go ? S_SPEED : S_DONE;
      S_SPEED:  state_next = S_ERR;
      S_ERR:    state_next = S_INTEG;
      S_INTEG:  state_next = S_PROP;
      S_PROP:   state_next = S_ILO;
      S_ILO:    state_next = S_IHI;
      S_IHI:    state_next = S_DER;
      S_DER:    state_next = S_SUM;
      S_SUM:    state_next = S_DRIVE;
      S_DRIVE:  state_next = S_DUTY;
      S_DUTY:   state_next = S_PWM;
      S_PWM:    state_next = S_SCALE;
      S_SCALE:  state_next = S_CMP;
      S_CMP:    state_next = S_DONE;
      S_DONE:   if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // multiplier issue per step
  always_comb begin
    mul_en = 1'b0;
    mul_a  = '0;
    mul_b  = '0;
    case (state)
      S_DECODE: begin
        mul_en = tick_go;
        mul_a  = $signed({11'b0, pulses_q});
        mul_b  = $signed({9'b0, cfg.rpm_per_pulse});
      end
      S_ERR: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(err);
        mul_b  = $signed({9'b0, cfg.period_seconds});
      end
      S_INTEG: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(err);
        mul_b  = $signed({1'b0, cfg.prop_gain});
      end
      S_PROP: begin
        mul_en = 1'b1;
        mul_a  = $signed({7'b0, integ[LO_W-1:0]});
        mul_b  = $signed({1'b0, cfg.integ_gain});
      end
      S_ILO: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'($signed(integ[INTEG_W-1:LO_W]));
        mul_b  = $signed({1'b0, cfg.integ_gain});
      end
      S_IHI: begin
        mul_en = 1'b1;
        mul_a  = MUL_W'(diff);
        mul_b  = $signed({1'b0, cfg.deriv_gain_per_period});
      end
      S_PWM: begin
        mul_en = 1'b1;
        mul_a  = $signed({10'b0, duty});
        mul_b  = $signed({9'b0, cfg.pwm_period_ticks});
      end
      S_SCALE: begin
        mul_en = 1'b1;
        mul_a  = $signed({2'b0, prod[30:8]});
        mul_b  = $signed({1'b0, RECIP_100});
      end
      default: ;
    endcase
  end

  // sequencer state
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // command latch and datapath registers
  always_ff @(posedge clk) begin
    if (accept) begin
      func_q   <= func_t'(cmd.func);
      motor_q  <= cmd.motor;
      pulses_q <= cmd.pulses;
      tgt_q    <= cmd.target_speed;
      dir_q    <= cmd.new_direction;
    end
    case (state)
      S_DECODE: ign <= in_range && (func_q == FUNC_DIR) && busy;
      S_SPEED:  err <= $signed({1'b0, target_store[mi]}) - $signed({1'b0, spd_sat});
      S_ERR:    diff <= DIFF_W'(err) - DIFF_W'(last_error_store[mi]);
      S_INTEG: begin
        if (isum > lim_pos) begin
          integ <= INTEG_W'(lim_pos);
        end else if (isum < lim_neg) begin
          integ <= INTEG_W'(lim_neg);
        end else begin
          integ <= INTEG_W'(isum);
        end
      end
      S_PROP:   sum <= SUM_W'(prod);
      S_ILO:    t_lo <= prod[TLO_W-1:0];
      S_IHI:    ifull <= (IFULL_W'($signed(prod[42:0])) <<< LO_W)
                         + $signed({19'b0, t_lo});
      S_DER:    sum <= sum + SUM_W'(ifull >>> 16);
      S_SUM:    sum <= sum + SUM_W'($signed(prod[45:0]));
      S_DRIVE: begin
        if (drive_full > $signed({13'b0, cfg.drive_limit})) begin
          drive <= cfg.drive_limit;
        end else if (drive_full < 0) begin
          drive <= '0;
        end else begin
          drive <= drive_full[DUTY_W-1:0];
        end
      end
      S_DUTY:   duty <= (drive > FULL_DRIVE) ? '0 : FULL_DRIVE - drive;
      default: ;
    endcase
  end

  // per-motor stores
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < MOTORS; i++) begin
        target_store[i]     <= '0;
        speed_store[i]      <= '0;
        running_flags[i]    <= 1'b0;
        integral_store[i]   <= '0;
        last_error_store[i] <= '0;
        compare_store[i]    <= '0;
        brake_store[i]      <= 1'b0;
        direction_store[i]  <= 1'b0;
      end
    end else begin
      case (state)
        S_DECODE: begin
          if (in_range) begin
            case (func_q)
              FUNC_TICK: begin
                if (!tick_go) begin
                  compare_store[mi]    <= '0;
                  integral_store[mi]   <= '0;
                  last_error_store[mi] <= '0;
                  speed_store[mi]      <= '0;
                end
              end
              FUNC_TARGET: begin
                target_store[mi] <= tgt_q;
                if (tgt_q != '0 && !running_flags[mi]) begin
                  brake_store[mi]   <= 1'b1;
                  running_flags[mi] <= 1'b1;
                end else if (tgt_q == '0 && running_flags[mi]) begin
                  running_flags[mi] <= 1'b0;
                  brake_store[mi]   <= 1'b0;
                  compare_store[mi] <= '0;
                end
              end
              FUNC_DIR: begin
                if (!busy) direction_store[mi] <= dir_q;
              end
              FUNC_ESTOP: begin
                running_flags[mi] <= 1'b0;
                target_store[mi]  <= '0;
                brake_store[mi]   <= 1'b0;
                compare_store[mi] <= '0;
              end
              default: ;
            endcase
          end
        end
        S_SPEED:  speed_store[mi] <= spd_sat;
        S_ERR:    last_error_store[mi] <= err;
        S_PROP:   integral_store[mi] <= integ;
        S_CMP: begin
          if (quot > {1'b0, cfg.pwm_period_ticks}) begin
            compare_store[mi] <= cfg.pwm_period_ticks;
          end else begin
            compare_store[mi] <= quot[CMP_W-1:0];
          end
        end
        default: ;
      endcase
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp.valid <= 1'b0;
    end else if (state == S_DONE && out_free) begin
      rsp.valid <= 1'b1;
    end else if (rsp.ready) begin
      rsp.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_DONE && out_free) begin
      rsp.motor_out <= motor_q;
      if (in_range) begin
        rsp.compare_value   <= compare_store[mi];
        rsp.brake_level     <= brake_store[mi];
        rsp.direction_level <= direction_store[mi];
        rsp.running         <= running_flags[mi];
        rsp.measured_speed  <= speed_store[mi];
        rsp.ignored         <= ign;
      end else begin
        rsp.compare_value   <= '0;
        rsp.brake_level     <= 1'b0;
        rsp.direction_level <= 1'b0;
        rsp.running         <= 1'b0;
        rsp.measured_speed  <= '0;
        rsp.ignored         <= 1'b0;
      end
    end
  end

  // a finished word waits while the previous one is still held
  a_done_hold: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && rsp.valid && !rsp.ready) |=> (state == S_DONE))
    else $error("response word overwritten while stalled");

  // a finished word is always presented next cycle
  a_done_load: assert property (@(posedge clk) disable iff (rst)
    (state == S_DONE && out_free) |=> rsp.valid)
    else $error("response word not loaded");

  for (genvar g = 0; g < MOTORS; g++) begin : g_chk
    // brake is released exactly while the motor runs
    a_brake_run: assert property (@(posedge clk) disable iff (rst)
      running_flags[g] == brake_store[g])
      else $error("brake and running flag disagree");

    // a stopped motor never holds a drive compare value
    a_stop_cmp: assert property (@(posedge clk) disable iff (rst)
      !running_flags[g] |-> (compare_store[g] == '0))
      else $error("stopped motor has nonzero compare");
  end

endmodule

// ----- rtl/dmpi_cfg.sv -----
// ----------------------------------------------------------------------------
// dmpi_cfg
// Configuration register file, written through a plain write port.
// ----------------------------------------------------------------------------
module dmpi_cfg (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      we,
  input  logic [2:0]                index,
  input  logic [dmpi_pkg::CFG_W-1:0] data,
  output dmpi_pkg::cfg_t            cfg
);
  import dmpi_pkg::*;

  // register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (we) begin
      case (reg_idx_t'(index))
        REG_RPM_PER_PULSE:  cfg.rpm_per_pulse         <= data[15:0];
        REG_PERIOD_SECONDS: cfg.period_seconds        <= data[15:0];
        REG_PROP_GAIN:      cfg.prop_gain             <= data[23:0];
        REG_INTEG_GAIN:     cfg.integ_gain            <= data[23:0];
        REG_DERIV_GAIN:     cfg.deriv_gain_per_period <= data[23:0];
        REG_INTEGRAL_LIMIT: cfg.integral_limit        <= data[35:0];
        REG_DRIVE_LIMIT:    cfg.drive_limit           <= data[14:0];
        REG_PWM_PERIOD:     cfg.pwm_period_ticks      <= data[15:0];
        default: ;
      endcase
    end
  end

endmodule

// ----- rtl/dmpi_mul.sv -----
// ----------------------------------------------------------------------------
// dmpi_mul
// Shared signed multiplier with a registered product, loaded on enable.
// ----------------------------------------------------------------------------
module dmpi_mul (
  input  logic                              clk,
  input  logic                              en,
  input  logic signed [dmpi_pkg::MUL_W-1:0] a,
  input  logic signed [dmpi_pkg::MUL_W-1:0] b,
  output logic signed [dmpi_pkg::PROD_W-1:0] prod
);
  import dmpi_pkg::*;

  // product register holds until the next issue
  always_ff @(posedge clk) begin
    if (en) begin
      prod <= PROD_W'(a) * PROD_W'(b);
    end
  end

endmodule

// ----- tb/tb_dual_motor_speed_pi_controller.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_dual_motor_speed_pi_controller
// Drives command words into the two-motor speed regulator and checks every
// response word against a cycle-free model of the regulator kept in the
// bench. A short directed run is followed by random runs under several
// register settings. Each run is mostly well-formed start/tick/stop
// sequences, with some random noise words mixed in. Both handshake sides
// stall at random, except in the last runs, where neither stalls.
// ----------------------------------------------------------------------------
module tb_dual_motor_speed_pi_controller;
  import dmpi_pkg::*;

  localparam int QUIET_LIMIT  = 4000;
  localparam int TAIL_CYCLES  = 24;
  localparam int PHASE_WORDS  = 95;
  localparam int RANDOM_RUNS  = 9;
  localparam int PULSE_MAX    = 10000;
  localparam longint FULL_DUTY = 25600;

  typedef struct {
    func_t       func;
    logic        motor;
    logic [13:0] pulses;
    logic [19:0] tgt;
    logic        dir;
  } cmd_word_t;

  typedef struct {
    logic        motor;
    logic [15:0] cmp;
    logic        brake;
    logic        dir;
    logic        running;
    logic [19:0] speed;
    logic        ignored;
  } status_word_t;

  logic clk = 1'b0;
  logic rst;
  logic              cfg_we;
  logic [2:0]        cfg_index;
  logic [CFG_W-1:0]  cfg_data;

  dmpi_cmd_if cmd_ch ();
  dmpi_rsp_if rsp_ch ();

  dual_motor_speed_pi_controller uut (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd_ch),
    .rsp       (rsp_ch),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // clock
  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // model copy of registers and per-motor state
  cfg_t        regs_m;
  logic [19:0] tgt_q   [2];
  logic [19:0] spd_q   [2];
  bit          run_q   [2];
  longint      integ_q [2];
  longint      lerr_q  [2];
  logic [15:0] cmp_q   [2];
  bit          brake_q [2];
  bit          dir_q   [2];

  cmd_word_t    pending_cmds [$];
  status_word_t predicted_status [$];

  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  bit          mism_seen;
  int unsigned quiet_cycles;
  cmd_word_t   drv_word;
  cmd_word_t   seen_cmd;
  status_word_t want_status;

  // stop: drops target, brake and compare, keeps the integral
  function automatic void halt_motor(int m);
    run_q[m]   = 1'b0;
    tgt_q[m]   = '0;
    brake_q[m] = 1'b0;
    cmp_q[m]   = '0;
  endfunction

  // one PID step of a motor on a control tick
  function automatic void speed_tick(int m, int unsigned pulses);
    longint spd, err, integ, lim, sum, drive, duty, cmpv;
    if (!run_q[m] || tgt_q[m] <= 20'd1) begin
      cmp_q[m]   = '0;
      integ_q[m] = 0;
      lerr_q[m]  = 0;
      spd_q[m]   = '0;
      return;
    end
    spd = longint'(pulses) * longint'(regs_m.rpm_per_pulse);
    if (spd > longint'(SPEED_MAX)) spd = longint'(SPEED_MAX);
    spd_q[m] = spd[19:0];

    err = longint'(tgt_q[m]) - spd;
    lim = longint'(regs_m.integral_limit);
    integ = integ_q[m] + err * longint'(regs_m.period_seconds);
    if (integ > lim) integ = lim;
    if (integ < -lim) integ = -lim;
    integ_q[m] = integ;

    // Q20 sum, floor shifts on signed values
    sum = err * longint'(regs_m.prop_gain)
        + ((integ * longint'(regs_m.integ_gain)) >>> 16)
        + (err - lerr_q[m]) * longint'(regs_m.deriv_gain_per_period);
    lerr_q[m] = err;

    drive = sum >>> 20;
    if (drive > longint'(regs_m.drive_limit)) drive = longint'(regs_m.drive_limit);
    if (drive < 0) drive = 0;

    // inverted duty into compare ticks
    duty = FULL_DUTY - drive;
    if (duty < 0) duty = 0;
    cmpv = (duty * longint'(regs_m.pwm_period_ticks)) / FULL_DUTY;
    if (cmpv > longint'(regs_m.pwm_period_ticks)) cmpv = longint'(regs_m.pwm_period_ticks);
    cmp_q[m] = cmpv[15:0];
  endfunction

  // status word the regulator reports after one command word
  function automatic status_word_t regulator_step(cmd_word_t c);
    status_word_t r;
    int m;
    m = int'(c.motor);
    r.ignored = 1'b0;
    case (c.func)
      FUNC_TICK: speed_tick(m, c.pulses);
      FUNC_TARGET: begin
        tgt_q[m] = c.tgt;
        if (c.tgt != '0 && !run_q[m]) begin
          brake_q[m] = 1'b1;
          run_q[m]   = 1'b1;
        end else if (c.tgt == '0 && run_q[m]) begin
          halt_motor(m);
        end
      end
      FUNC_DIR: begin
        if (tgt_q[m] != '0 || run_q[m]) r.ignored = 1'b1;
        else dir_q[m] = c.dir;
      end
      default: halt_motor(m);
    endcase
    r.motor   = c.motor;
    r.cmp     = cmp_q[m];
    r.brake   = brake_q[m];
    r.dir     = dir_q[m];
    r.running = run_q[m];
    r.speed   = spd_q[m];
    return r;
  endfunction

  function automatic void check_field(string name, longint unsigned want, longint unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, actual %0d", name, want, got);
      mism_seen = 1'b1;
    end
  endfunction

  // command driver
  always @(posedge clk) begin
    if (rst) begin
      cmd_ch.valid <= 1'b0;
    end else if (!cmd_ch.valid || cmd_ch.ready) begin
      if (pending_cmds.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
        drv_word = pending_cmds.pop_front();
        cmd_ch.valid         <= 1'b1;
        cmd_ch.func          <= drv_word.func;
        cmd_ch.motor         <= drv_word.motor;
        cmd_ch.pulses        <= drv_word.pulses;
        cmd_ch.target_speed  <= drv_word.tgt;
        cmd_ch.new_direction <= drv_word.dir;
      end else begin
        cmd_ch.valid <= 1'b0;
      end
    end
  end

  // response receiver stalls
  always @(posedge clk) begin
    rsp_ch.ready <= !rst && ($urandom_range(0, 99) >= recv_idle_pct);
  end

  // monitor: check responses, predict accepted commands, watchdog
  always @(posedge clk) begin
    if (rst) begin
      mism_seen    = 1'b0;
      quiet_cycles = 0;
      for (int m = 0; m < 2; m++) begin
        tgt_q[m]   = '0;
        spd_q[m]   = '0;
        run_q[m]   = 1'b0;
        integ_q[m] = 0;
        lerr_q[m]  = 0;
        cmp_q[m]   = '0;
        brake_q[m] = 1'b0;
        dir_q[m]   = 1'b0;
      end
    end else begin
      if (rsp_ch.valid && rsp_ch.ready) begin
        if (predicted_status.size() == 0) begin
          $error("response word with no command pending");
          mism_seen = 1'b1;
        end else begin
          want_status = predicted_status.pop_front();
          check_field("motor_out", want_status.motor, rsp_ch.motor_out);
          check_field("compare_value", want_status.cmp, rsp_ch.compare_value);
          check_field("brake_level", want_status.brake, rsp_ch.brake_level);
          check_field("direction_level", want_status.dir, rsp_ch.direction_level);
          check_field("running", want_status.running, rsp_ch.running);
          check_field("measured_speed", want_status.speed, rsp_ch.measured_speed);
          check_field("ignored", want_status.ignored, rsp_ch.ignored);
        end
      end
      if (cmd_ch.valid && cmd_ch.ready) begin
        seen_cmd.func   = func_t'(cmd_ch.func);
        seen_cmd.motor  = cmd_ch.motor;
        seen_cmd.pulses = cmd_ch.pulses;
        seen_cmd.tgt    = cmd_ch.target_speed;
        seen_cmd.dir    = cmd_ch.new_direction;
        predicted_status.push_back(regulator_step(seen_cmd));
      end
      if ((cmd_ch.valid && cmd_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
        quiet_cycles = 0;
      end else begin
        quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("end of test: mismatches");
          $finish;
        end
      end
    end
  end

  function automatic void push_cmd(func_t f, int m, int unsigned p, int unsigned t, int d);
    cmd_word_t w;
    w.func   = f;
    w.motor  = m[0];
    w.pulses = p[13:0];
    w.tgt    = t[19:0];
    w.dir    = d[0];
    pending_cmds.push_back(w);
  endfunction

  // wait until every queued word has been answered
  task automatic wait_drained();
    do @(negedge clk);
    while (pending_cmds.size() != 0 || cmd_ch.valid || predicted_status.size() != 0);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  task automatic apply_settings(cfg_t s);
    write_reg(REG_RPM_PER_PULSE, CFG_W'(s.rpm_per_pulse));
    write_reg(REG_PERIOD_SECONDS, CFG_W'(s.period_seconds));
    write_reg(REG_PROP_GAIN, CFG_W'(s.prop_gain));
    write_reg(REG_INTEG_GAIN, CFG_W'(s.integ_gain));
    write_reg(REG_DERIV_GAIN, CFG_W'(s.deriv_gain_per_period));
    write_reg(REG_INTEGRAL_LIMIT, s.integral_limit);
    write_reg(REG_DRIVE_LIMIT, CFG_W'(s.drive_limit));
    write_reg(REG_PWM_PERIOD, CFG_W'(s.pwm_period_ticks));
    regs_m = s;
  endtask

  // pulse count that lands the speed near the target
  function automatic int unsigned near_pulses(int unsigned t);
    int p;
    if (regs_m.rpm_per_pulse == '0) return $urandom_range(0, PULSE_MAX);
    p = int'(t / regs_m.rpm_per_pulse) + int'($urandom_range(0, 6)) - 3;
    if ($urandom_range(0, 9) == 0) p = int'($urandom_range(0, PULSE_MAX));
    if (p < 0) p = 0;
    if (p > PULSE_MAX) p = PULSE_MAX;
    return p;
  endfunction

  // start, run and maybe stop one motor; returns words queued
  function automatic int add_run();
    int m, n, words;
    int unsigned t;
    m = $urandom_range(0, 1);
    t = ($urandom_range(0, 1) != 0) ? $urandom_range(2, 1048575) : $urandom_range(2, 40000);
    push_cmd(FUNC_TARGET, m, 0, t, $urandom_range(0, 1));
    words = 1;
    n = $urandom_range(3, 12);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2 && $urandom_range(0, 3) == 0) begin
        t = $urandom_range(2, 1048575);
        push_cmd(FUNC_TARGET, m, 0, t, 0);
        words++;
      end
      if ($urandom_range(0, 9) == 0) begin
        push_cmd(FUNC_DIR, m, 0, 0, $urandom_range(0, 1));
        words++;
      end
      push_cmd(FUNC_TICK, m, near_pulses(t), 0, 0);
      words++;
    end
    case ($urandom_range(0, 2))
      0: begin
        push_cmd(FUNC_ESTOP, m, 0, 0, 0);
        words++;
      end
      1: begin
        push_cmd(FUNC_TARGET, m, 0, 0, 0);
        words++;
      end
      default: ;
    endcase
    if ($urandom_range(0, 9) < 4) begin
      push_cmd(FUNC_DIR, m, 0, 0, $urandom_range(0, 1));
      words++;
    end
    return words;
  endfunction

  // fully random word
  task automatic add_noise();
    int unsigned t;
    case ($urandom_range(0, 9))
      0, 1:    t = 0;
      2:       t = 1;
      default: t = $urandom_range(0, 1048575);
    endcase
    push_cmd(func_t'($urandom_range(0, 3)), $urandom_range(0, 1),
             $urandom_range(0, PULSE_MAX), t, $urandom_range(0, 1));
  endtask

  function automatic cfg_t random_settings();
    cfg_t s;
    s.rpm_per_pulse         = 16'($urandom_range(0, 65535));
    s.period_seconds        = 16'($urandom_range(1, 65535));
    s.prop_gain             = 24'($urandom_range(0, 24'hFFFFFF));
    s.integ_gain            = 24'($urandom_range(0, 24'hFFFFFF));
    s.deriv_gain_per_period = 24'($urandom_range(0, 24'hFFFFFF));
    s.integral_limit        = {4'($urandom_range(0, 15)), $urandom()};
    s.drive_limit           = 15'($urandom_range(0, 25600));
    s.pwm_period_ticks      = 16'($urandom_range(1, 65535));
    return s;
  endfunction

  // main sequence
  initial begin
    cfg_t s;
    int words;
    rst                  = 1'b1;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    send_idle_pct        = 22;
    recv_idle_pct        = 72;
    regs_m               = CFG_RESET;
    repeat (9) @(posedge clk);
    rst <= 1'b0;

    // directed words under reset settings
    push_cmd(FUNC_TICK, 0, 10000, 0, 0);     // tick on a stopped motor
    push_cmd(FUNC_DIR, 0, 0, 0, 1);
    push_cmd(FUNC_DIR, 1, 0, 0, 1);
    push_cmd(FUNC_TARGET, 0, 0, 1, 0);       // target of one runs but never drives
    push_cmd(FUNC_TICK, 0, 5, 0, 0);
    push_cmd(FUNC_TARGET, 0, 0, 1048575, 0);
    push_cmd(FUNC_TICK, 0, 0, 0, 0);
    push_cmd(FUNC_TICK, 0, 10000, 0, 0);     // speed saturates
    push_cmd(FUNC_TICK, 0, 8192, 0, 0);
    push_cmd(FUNC_DIR, 0, 0, 0, 0);          // refused while running
    push_cmd(FUNC_TARGET, 0, 0, 0, 0);       // zero target stops
    push_cmd(FUNC_DIR, 0, 0, 0, 0);
    push_cmd(FUNC_TARGET, 1, 0, 16000, 0);
    push_cmd(FUNC_TICK, 1, 2, 0, 0);
    push_cmd(FUNC_TICK, 1, 3, 0, 0);
    push_cmd(FUNC_TARGET, 1, 0, 30000, 0);   // retarget while running
    push_cmd(FUNC_TICK, 1, 5, 0, 0);
    push_cmd(FUNC_ESTOP, 1, 0, 0, 0);        // integral kept over e-stop
    push_cmd(FUNC_DIR, 1, 0, 0, 0);
    push_cmd(FUNC_TICK, 1, 3, 0, 0);
    push_cmd(FUNC_TARGET, 0, 0, 0, 0);       // zero target on a stopped motor
    push_cmd(FUNC_ESTOP, 0, 0, 0, 0);
    push_cmd(FUNC_TARGET, 0, 0, 2, 0);
    push_cmd(FUNC_TICK, 0, 0, 0, 0);
    wait_drained();

    // random runs, one register setting each
    for (int ph = 0; ph < RANDOM_RUNS; ph++) begin
      case (ph)
        0: begin
          // every register at its top, drive limit above full scale
          s.rpm_per_pulse         = 16'hFFFF;
          s.period_seconds        = 16'hFFFF;
          s.prop_gain             = 24'hFFFFFF;
          s.integ_gain            = 24'hFFFFFF;
          s.deriv_gain_per_period = 24'hFFFFFF;
          s.integral_limit        = 36'hFFFFFFFFF;
          s.drive_limit           = 15'h7FFF;
          s.pwm_period_ticks      = 16'hFFFF;
        end
        1: begin
          // everything at the bottom, period_seconds at one, PWM period of zero
          s.rpm_per_pulse         = '0;
          s.period_seconds        = 16'd1;
          s.prop_gain             = '0;
          s.integ_gain            = '0;
          s.deriv_gain_per_period = '0;
          s.integral_limit        = '0;
          s.drive_limit           = '0;
          s.pwm_period_ticks      = '0;
        end
        2: begin
          s = CFG_RESET;
          s.deriv_gain_per_period = 24'd1 << 20;
          s.drive_limit           = 15'd25600;
        end
        8: s = CFG_RESET;
        default: s = random_settings();
      endcase
      if (ph < 3) begin
        send_idle_pct = 22;
        recv_idle_pct = 72;
      end else if (ph < 6) begin
        send_idle_pct = 72;
        recv_idle_pct = 22;
      end else begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
      end
      apply_settings(s);
      words = 0;
      while (words < PHASE_WORDS) begin
        if ($urandom_range(0, 9) < 7) begin
          words += add_run();
        end else begin
          add_noise();
          words++;
        end
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    if (!mism_seen && predicted_status.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
